/* rtl/core/tvsg_pkg.sv */
// Shared types, constants and tables for the three-voice sound generator.
package tvsg_pkg;

    localparam int unsigned STEP_LIMIT_DEFAULT = 1000000;
    localparam int unsigned STEP_W = 20;
    localparam int unsigned QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        OP_SELECT = 2'd0,
        OP_WRITE  = 2'd1,
        OP_READ   = 2'd2,
        OP_RENDER = 2'd3
    } t_op;

    localparam logic [3:0] REG_MIXER     = 4'd7;
    localparam logic [3:0] REG_AMP_A     = 4'd8;
    localparam logic [3:0] REG_ENV_FINE  = 4'd11;
    localparam logic [3:0] REG_ENV_COARSE = 4'd12;
    localparam logic [3:0] REG_SHAPE     = 4'd13;
    localparam logic [3:0] REG_NOISE     = 4'd6;

    // one classified beat handed from front to back
    typedef struct packed {
        t_op                op;
        logic [7:0]         value;
        logic [STEP_W-1:0]  steps;
    } t_cmd;

    function automatic logic [14:0] vol_lut(input logic [3:0] idx);
        logic [14:0] r;
        unique case (idx)
            4'd0:  r = 15'd0;
            4'd1:  r = 15'd1304;
            4'd2:  r = 15'd1642;
            4'd3:  r = 15'd2067;
            4'd4:  r = 15'd2603;
            4'd5:  r = 15'd3277;
            4'd6:  r = 15'd4125;
            4'd7:  r = 15'd5193;
            4'd8:  r = 15'd6538;
            4'd9:  r = 15'd8231;
            4'd10: r = 15'd10362;
            4'd11: r = 15'd13045;
            4'd12: r = 15'd16422;
            4'd13: r = 15'd20675;
            4'd14: r = 15'd26028;
            default: r = 15'd32767;
        endcase
        return r;
    endfunction

endpackage

/* rtl/core/tvsg_if.sv */
// Valid/ready channel interfaces for the sound generator.
interface tvsg_in_if;
    import tvsg_pkg::*;
    logic       valid;
    logic       ready;
    logic [1:0] operation;
    logic [7:0] bus_value;
    logic [19:0] step_count;
    modport source(output valid, operation, bus_value, step_count, input ready);
    modport sink(input valid, operation, bus_value, step_count, output ready);
endinterface

interface tvsg_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  read_value;
    logic [14:0] sample;
    logic        sample_valid;
    modport source(output valid, read_value, sample, sample_valid, input ready);
    modport sink(input valid, read_value, sample, sample_valid, output ready);
endinterface

/* rtl/core/tvsg_front.sv */
// Front end: accepts beats, clamps step counts and queues commands.
module tvsg_front
    import tvsg_pkg::*;
#(
    parameter int unsigned STEP_LIMIT = STEP_LIMIT_DEFAULT
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tvsg_in_if.sink    i_in,
    output logic       o_cmd_valid,
    output t_cmd       o_cmd,
    input  logic       i_cmd_pop
);
    localparam logic [STEP_W-1:0] LIMIT = STEP_W'(STEP_LIMIT);

    t_cmd       r_q [QUEUE_DEPTH];
    logic       r_wp, n_wp, r_rp, n_rp;
    logic [1:0] r_cnt, n_cnt;
    logic       push;
    t_cmd       cmd_in;

    assign i_in.ready = (r_cnt != 2'(QUEUE_DEPTH));
    assign push = i_in.valid && i_in.ready;

    always_comb begin
        cmd_in.op    = t_op'(i_in.operation);
        cmd_in.value = i_in.bus_value;
        cmd_in.steps = (i_in.step_count > LIMIT) ? LIMIT : i_in.step_count;
    end

    always_comb begin
        n_wp  = push ? ~r_wp : r_wp;
        n_rp  = i_cmd_pop ? ~r_rp : r_rp;
        n_cnt = r_cnt + 2'(push) - 2'(i_cmd_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= 2'd0;
        end else begin
            r_wp <= n_wp; r_rp <= n_rp; r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= cmd_in;
        end
    end

    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];
endmodule

/* rtl/core/tvsg_back.sv */
// Back end: register file, tone/noise/envelope generators and mixer.
module tvsg_back
    import tvsg_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cmd_valid,
    input  t_cmd       i_cmd,
    output logic       o_cmd_pop,
    tvsg_out_if.source o_out
);
    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_STEP = 4'b0010,
        ST_MIX  = 4'b0100,
        ST_DIV  = 4'b1000
    } t_state;

    t_state      r_st, n_st;
    logic [7:0]  r_regs [16];
    logic [3:0]  r_sel;
    logic [11:0] r_tcnt [3];
    logic [2:0]  r_tlev;
    logic [4:0]  r_ncnt;
    logic [16:0] r_lfsr;
    logic        r_nlev;
    logic [15:0] r_ecnt;
    logic [5:0]  r_epos;
    logic        r_erise, r_efroz;
    logic [STEP_W-1:0] r_left;
    logic [16:0] r_sum;
    logic        r_ov;
    logic [7:0]  r_rd;
    logic [14:0] r_smp;
    logic        r_sv;

    logic        out_free, do_step, load_out;
    logic [3:0]  env_lvl;
    logic [16:0] mix_sum;
    logic [14:0] quot;

    assign out_free = !r_ov || o_out.ready;
    assign o_cmd_pop = i_cmd_valid && (r_st == ST_IDLE) && out_free &&
                       !(i_cmd.op == OP_RENDER && i_cmd.steps != '0) &&
                       i_cmd.op != OP_RENDER
                     || (r_st == ST_DIV && out_free);
    assign do_step = (r_st == ST_STEP);
    // a result beat is loaded for every bus op and at the end of a render
    assign load_out = (r_st == ST_IDLE && i_cmd_valid && out_free &&
                       i_cmd.op != OP_RENDER) || (r_st == ST_DIV && out_free);

    always_comb begin
        logic [4:0] p;
        logic [4:0] q;
        p = r_epos[4:0];
        q = 5'd31 - p;
        if (!r_regs[REG_SHAPE][3] && r_efroz) env_lvl = 4'd0;
        else env_lvl = r_erise ? p[4:1] : q[4:1];
    end

    always_comb begin
        logic [3:0] idx;
        logic tb, nb;
        mix_sum = '0;
        for (int v = 0; v < 3; v++) begin
            tb = r_regs[REG_MIXER][v] || r_tlev[v];
            nb = r_regs[REG_MIXER][v+3] || r_nlev;
            idx = r_regs[REG_AMP_A + 4'(v)][4] ? env_lvl : r_regs[REG_AMP_A + 4'(v)][3:0];
            if (tb && nb) mix_sum = mix_sum + 17'(vol_lut(idx));
        end
    end

    // divide by three via reciprocal multiply: sum < 2^17
    always_comb begin
        logic [34:0] prod;
        prod = 35'(r_sum) * 35'd43691;
        quot = prod[31:17];
    end

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            ST_IDLE: if (i_cmd_valid && out_free && i_cmd.op == OP_RENDER)
                n_st = (i_cmd.steps != '0) ? ST_STEP : ST_MIX;
            ST_STEP: if (r_left == STEP_W'(1)) n_st = ST_MIX;
            ST_MIX:  n_st = ST_DIV;
            ST_DIV:  if (out_free) n_st = ST_IDLE;
            default: n_st = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        logic [11:0] tp;
        logic [4:0]  np;
        logic [15:0] ep;
        logic [5:0]  pos;
        if (!i_rst_n) begin
            r_st <= ST_IDLE;
            for (int i = 0; i < 16; i++) r_regs[i] <= 8'd0;
            r_sel <= '0;
            for (int v = 0; v < 3; v++) r_tcnt[v] <= '0;
            r_tlev <= 3'b111; r_ncnt <= '0; r_lfsr <= 17'd1; r_nlev <= 1'b1;
            r_ecnt <= '0; r_epos <= '0; r_erise <= 1'b1; r_efroz <= 1'b0;
            r_ov <= 1'b0; r_left <= '0;
        end else begin
            r_st <= n_st;
            if (load_out) r_ov <= 1'b1;
            else if (o_out.ready) r_ov <= 1'b0;
            if (r_st == ST_IDLE && i_cmd_valid && out_free) begin
                unique case (i_cmd.op)
                    OP_SELECT: begin
                        r_sel <= i_cmd.value[3:0];
                        r_rd <= '0; r_smp <= '0; r_sv <= 1'b0;
                    end
                    OP_WRITE: begin
                        r_regs[r_sel] <= i_cmd.value;
                        if (r_sel == REG_SHAPE) begin
                            r_epos <= '0; r_efroz <= 1'b0; r_erise <= i_cmd.value[2];
                        end
                        r_rd <= '0; r_smp <= '0; r_sv <= 1'b0;
                    end
                    OP_READ: begin
                        r_rd <= r_regs[r_sel]; r_smp <= '0; r_sv <= 1'b0;
                    end
                    OP_RENDER: r_left <= i_cmd.steps;
                    default: ;
                endcase
            end
            if (do_step) begin
                r_left <= r_left - STEP_W'(1);
                for (int v = 0; v < 3; v++) begin
                    tp = {r_regs[2*v+1][3:0], r_regs[2*v]};
                    if (tp == '0) tp = 12'd1;
                    if (r_tcnt[v] + 12'd1 >= tp || r_tcnt[v] == 12'hfff) begin
                        r_tcnt[v] <= '0; r_tlev[v] <= ~r_tlev[v];
                    end else r_tcnt[v] <= r_tcnt[v] + 12'd1;
                end
                np = r_regs[REG_NOISE][4:0];
                if (np == '0) np = 5'd1;
                if (r_ncnt + 5'd1 >= np || r_ncnt == 5'h1f) begin
                    r_ncnt <= '0;
                    r_lfsr <= {r_lfsr[0] ^ r_lfsr[3], r_lfsr[16:1]};
                    r_nlev <= r_lfsr[1];
                end else r_ncnt <= r_ncnt + 5'd1;
                ep = {r_regs[REG_ENV_COARSE], r_regs[REG_ENV_FINE]};
                if (ep == '0) ep = 16'd1;
                if (r_ecnt + 16'd1 >= ep || r_ecnt == 16'hffff) begin
                    r_ecnt <= '0;
                    if (!r_efroz) begin
                        pos = r_epos + 6'd1;
                        if (pos >= 6'd32) begin
                            if (!r_regs[REG_SHAPE][3]) begin
                                r_epos <= 6'd32; r_efroz <= 1'b1;
                            end else if (r_regs[REG_SHAPE][0]) begin
                                r_epos <= 6'd31; r_efroz <= 1'b1;
                                if (r_regs[REG_SHAPE][1]) r_erise <= ~r_erise;
                            end else begin
                                r_epos <= 6'd0;
                                if (r_regs[REG_SHAPE][1]) r_erise <= ~r_erise;
                            end
                        end else r_epos <= pos;
                    end
                end else r_ecnt <= r_ecnt + 16'd1;
            end
            if (r_st == ST_MIX) r_sum <= mix_sum;
            if (r_st == ST_DIV && out_free) begin
                r_rd <= '0; r_smp <= quot; r_sv <= 1'b1;
            end
        end
    end

    assign o_out.valid        = r_ov;
    assign o_out.read_value   = r_rd;
    assign o_out.sample       = r_smp;
    assign o_out.sample_valid = r_sv;
endmodule

/* rtl/core/three_voice_sound_generator.sv */
// Top level of the three-voice sound generator.
// Usage:
//   i_in carries bus beats: select, write, read or render (with a step count).
//   o_out gives exactly one result beat per input beat, in order.
//   Select, write and read results are registered in the result register.
//   A render runs min(step_count, STEP_LIMIT) internal steps, one step per
//   cycle in the back end's generator unit, then a mix state and a divide
//   state before its result is registered.
//   A two-entry command queue separates the front end from the back end,
//   so new beats are accepted while a render runs or a result waits.
//   When the receiver stalls, the result register holds and the queue fills;
//   i_in.ready drops when the queue is full.
//   Reset (synchronous, active low) clears the register file, the generator
//   state and the queue; the block is ready in the first cycle after reset.
module three_voice_sound_generator
    import tvsg_pkg::*;
#(
    parameter int unsigned STEP_LIMIT = STEP_LIMIT_DEFAULT
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tvsg_in_if.sink    i_in,
    tvsg_out_if.source o_out
);
    logic cmd_valid, cmd_pop;
    t_cmd cmd;

    tvsg_front #(.STEP_LIMIT(STEP_LIMIT)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(i_in),
        .o_cmd_valid(cmd_valid), .o_cmd(cmd), .i_cmd_pop(cmd_pop)
    );

    tvsg_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd_valid(cmd_valid),
        .i_cmd(cmd), .o_cmd_pop(cmd_pop), .o_out(o_out)
    );
endmodule

/* rtl/core/tvsg_checker.sv */
// Port-level checker for the sound generator, bound to the top level.
module tvsg_port_props (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [7:0]  read_value,
    input logic [14:0] sample,
    input logic        sample_valid
);
    a_read_no_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && read_value != 8'd0 |-> !sample_valid && sample == 15'd0)
        else $error("read result carries a sample");
    a_nonrender_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !sample_valid |-> sample == 15'd0)
        else $error("non-render result has non-zero sample");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid && $stable(sample) && $stable(read_value))
        else $error("stalled result changed");
    a_ready_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !out_valid)
        else $error("result valid after reset");
    a_in_ready_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> in_ready)
        else $error("input not ready after reset");
endmodule

bind three_voice_sound_generator tvsg_port_props u_tvsg_port_props (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .in_ready(i_in.ready),
    .out_valid(o_out.valid), .out_ready(o_out.ready),
    .read_value(o_out.read_value), .sample(o_out.sample),
    .sample_valid(o_out.sample_valid)
);
